/* rtl/core/cins_pkg.sv */
// ----------------------------------------------------------------------------
// cins_pkg
// Shared types, constants and helpers of the CDF inversion noise sampler.
// ----------------------------------------------------------------------------
package cins_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HI_N        = (TABLE_DEPTH + 1) / 2;

    localparam int WORD_W  = 16;
    localparam int DRAW_W  = 15;
    localparam int SIGN_BIT = 15;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] MOD_BITS_RST  = 5'd15;
    localparam logic [CFG_W-1:0] TABLE_LEN_RST = 5'd13;

    typedef enum logic {
        CMD_DRAW  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        REG_MODULUS_BITS = 1'b0,
        REG_TABLE_LENGTH = 1'b1
    } t_reg;

    typedef logic [TABLE_DEPTH-1:0][WORD_W-1:0] t_table;
    typedef logic [TABLE_DEPTH-1:0]             t_use;

    typedef struct packed {
        logic valid;
        logic sign;
        logic last;
    } t_ctrl;

    function automatic logic [WORD_W-1:0] f_mod_mask(input logic [CFG_W-1:0] bits);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (int'(bits) > b);
        end
        return m;
    endfunction

    function automatic t_use f_use_mask(input logic [CFG_W-1:0] len);
        t_use u;
        u = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            u[k] = (int'(len) > k);
        end
        return u;
    endfunction

endpackage

/* rtl/core/cins_rank.sv */
// ----------------------------------------------------------------------------
// cins_rank
// Two-stage rank unit: compares the draw against every enabled table entry,
// then counts the hits in two registered halves.
// ----------------------------------------------------------------------------
module cins_rank (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cins_pkg::t_ctrl                     i_ctrl,
    input  logic [cins_pkg::DRAW_W-1:0]         i_draw,
    input  cins_pkg::t_table                    i_table,
    input  cins_pkg::t_use                      i_use,
    output cins_pkg::t_ctrl                     o_ctrl,
    output logic [cins_pkg::CNT_W-1:0]          o_cnt_lo,
    output logic [cins_pkg::CNT_W-1:0]          o_cnt_hi
);

    cins_pkg::t_ctrl                    r_ctrl_c;
    cins_pkg::t_use                     r_hit;
    cins_pkg::t_use                     n_hit;
    cins_pkg::t_ctrl                    r_ctrl_n;
    logic [cins_pkg::CNT_W-1:0]         r_cnt_lo;
    logic [cins_pkg::CNT_W-1:0]         r_cnt_hi;
    logic [cins_pkg::CNT_W-1:0]         n_cnt_lo;
    logic [cins_pkg::CNT_W-1:0]         n_cnt_hi;

    always_comb begin
        for (int k = 0; k < cins_pkg::TABLE_DEPTH; k++) begin
            n_hit[k] = i_use[k] && (i_table[k] <= cins_pkg::WORD_W'(i_draw));
        end
    end

    always_comb begin
        n_cnt_lo = '0;
        n_cnt_hi = '0;
        for (int k = 0; k < cins_pkg::TABLE_DEPTH; k++) begin
            if (k < cins_pkg::HI_N) begin
                n_cnt_lo = n_cnt_lo + cins_pkg::CNT_W'(r_hit[k]);
            end else begin
                n_cnt_hi = n_cnt_hi + cins_pkg::CNT_W'(r_hit[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_c.valid <= 1'b0;
            r_ctrl_n.valid <= 1'b0;
        end else begin
            r_ctrl_c.valid <= i_ctrl.valid;
            r_ctrl_n.valid <= r_ctrl_c.valid;
        end
        r_ctrl_c.sign <= i_ctrl.sign;
        r_ctrl_c.last <= i_ctrl.last;
        r_ctrl_n.sign <= r_ctrl_c.sign;
        r_ctrl_n.last <= r_ctrl_c.last;
        r_hit         <= n_hit;
        r_cnt_lo      <= n_cnt_lo;
        r_cnt_hi      <= n_cnt_hi;
    end

    assign o_ctrl   = r_ctrl_n;
    assign o_cnt_lo = r_cnt_lo;
    assign o_cnt_hi = r_cnt_hi;

endmodule

/* rtl/core/cdf_inversion_noise_sampler.sv */
// ----------------------------------------------------------------------------
// cdf_inversion_noise_sampler
// Error sampler by inversion of a cumulative distribution table.
// ----------------------------------------------------------------------------
// One request per clock: busy stays low and a request is taken whenever start
// is high. A draw request gives its result on o_noise_value with o_valid high
// for one cycle; the result passes through the input register, the compare
// stage, the count stage and the output stage. A table write request gives no
// result and is visible to a draw taken on the next edge. Configuration writes
// are always ready and take effect at once.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module cdf_inversion_noise_sampler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [15:0]                     i_random_word,
    input  logic [3:0]                      i_entry_index,
    input  logic [15:0]                     i_entry_value,
    input  logic                            i_last_sample,
    output logic                            o_valid,
    output logic [15:0]                     o_noise_value,
    output logic                            o_last_of_matrix,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [0:0]                      i_cfg_index,
    input  logic [cins_pkg::CFG_W-1:0]      i_cfg_data
);

    logic                               acc;
    logic                               wr_en;
    logic [cins_pkg::IDX_W-1:0]         wr_idx;

    cins_pkg::t_table                   r_table;
    logic [cins_pkg::WORD_W-1:0]        r_mod_mask;
    cins_pkg::t_use                     r_use;

    cins_pkg::t_ctrl                    r_ctrl_in;
    logic [cins_pkg::DRAW_W-1:0]        r_draw;

    cins_pkg::t_ctrl                    rank_ctrl;
    logic [cins_pkg::CNT_W-1:0]         cnt_lo;
    logic [cins_pkg::CNT_W-1:0]         cnt_hi;

    logic [cins_pkg::CNT_W-1:0]         mag;
    logic [cins_pkg::WORD_W-1:0]        n_noise;
    logic                               r_valid;
    logic [cins_pkg::WORD_W-1:0]        r_noise;
    logic                               r_last;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;
    assign wr_en       = acc && (i_command == cins_pkg::CMD_WRITE)
                         && (int'(i_entry_index) < cins_pkg::TABLE_DEPTH);
    assign wr_idx      = cins_pkg::IDX_W'(i_entry_index);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_mask <= cins_pkg::f_mod_mask(cins_pkg::MOD_BITS_RST);
            r_use      <= cins_pkg::f_use_mask(cins_pkg::TABLE_LEN_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (cins_pkg::t_reg'(i_cfg_index))
                cins_pkg::REG_MODULUS_BITS: begin
                    r_mod_mask <= cins_pkg::f_mod_mask(i_cfg_data);
                end
                cins_pkg::REG_TABLE_LENGTH: begin
                    r_use <= cins_pkg::f_use_mask(i_cfg_data);
                end
                default: begin
                    r_use <= r_use;
                end
            endcase
        end
    end

    // table store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_idx] <= i_entry_value;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_in.valid <= 1'b0;
        end else begin
            r_ctrl_in.valid <= acc && (i_command == cins_pkg::CMD_DRAW);
        end
        r_ctrl_in.sign <= i_random_word[cins_pkg::SIGN_BIT];
        r_ctrl_in.last <= i_last_sample;
        r_draw         <= i_random_word[cins_pkg::DRAW_W-1:0];
    end

    cins_rank u_rank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (r_ctrl_in),
        .i_draw   (r_draw),
        .i_table  (r_table),
        .i_use    (r_use),
        .o_ctrl   (rank_ctrl),
        .o_cnt_lo (cnt_lo),
        .o_cnt_hi (cnt_hi)
    );

    // output stage
    always_comb begin
        mag     = cnt_lo + cnt_hi;
        n_noise = rank_ctrl.sign ? (cins_pkg::WORD_W'(0) - cins_pkg::WORD_W'(mag))
                                 : cins_pkg::WORD_W'(mag);
        n_noise = n_noise & r_mod_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= rank_ctrl.valid;
        end
        r_noise <= n_noise;
        r_last  <= rank_ctrl.last;
    end

    assign o_valid          = r_valid;
    assign o_noise_value    = r_noise;
    assign o_last_of_matrix = r_last;

endmodule

/* rtl/core/cins_checker.sv */
// ----------------------------------------------------------------------------
// cins_checker
// Port-level checks of the noise sampler, bound to the top level.
// ----------------------------------------------------------------------------
module cins_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_random_word,
    input  logic        i_last_sample,
    input  logic        o_valid,
    input  logic [15:0] o_noise_value,
    input  logic        o_last_of_matrix
);

    logic draw_acc;

    assign draw_acc = start && !busy && (i_command == cins_pkg::CMD_DRAW);

    a_draw_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_acc |-> ##4 o_valid)
        else $error("draw request gave no result");

    a_result_has_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(draw_acc, 4))
        else $error("result without draw request");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(draw_acc, 4)) |-> (o_last_of_matrix == $past(i_last_sample, 4)))
        else $error("last marker mismatch");

    a_positive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(draw_acc, 4) && !$past(i_random_word[15], 4))
        |-> (int'(o_noise_value) <= cins_pkg::TABLE_DEPTH))
        else $error("positive sample above table depth");

endmodule

bind cdf_inversion_noise_sampler cins_checker u_cins_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_command        (i_command),
    .i_random_word    (i_random_word),
    .i_last_sample    (i_last_sample),
    .o_valid          (o_valid),
    .o_noise_value    (o_noise_value),
    .o_last_of_matrix (o_last_of_matrix)
);
